// ===== src/svms_pkg.sv =====
// ----------------------------------------------------------------------------
// svms_pkg
// Shared constants, types and the coil phase table of the valve move sequencer.
// ----------------------------------------------------------------------------
package svms_pkg;

   localparam int NUM_VALVES       = 12;
   localparam int MAX_POSITION     = 24;
   localparam int VALVES_PER_CHAIN = 6;

   localparam int VALVE_W   = 4;
   localparam int POS_W     = 5;
   localparam int AMOUNT_W  = 5;
   localparam int SPU_W     = 8;
   localparam int WORDS_W   = 15;
   localparam int WORD_W    = 24;
   localparam int SLOT_W    = 3;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_MODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STORE_POSITIONS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_PER_UNIT  = 2'd2;

   localparam logic [SPU_W-1:0] SPU_RESET = 8'd24;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_MOVE   = 2'd1,
      CMD_TARGET = 2'd2,
      CMD_LOAD   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_BUSY     = 2'd1,
      ST_RANGE    = 2'd2,
      ST_AMOUNT   = 2'd3
   } status_type;

   typedef enum logic {
      KIND_DRIVE  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [VALVE_W-1:0]    valve;
      logic                  valve_ok;
      logic                  chain;
      logic                  dir;
      logic [AMOUNT_W-1:0]   amount;
      logic [POS_W-1:0]      target;
   } item_type;

   typedef struct packed {
      kind_type              kind;
      logic [WORD_W-1:0]     word;
      logic                  chain;
      logic                  last;
      status_type            status;
      logic [POS_W-1:0]      pos;
   } rsp_type;

   function automatic logic [3:0] phase_nibble(input logic [1:0] ph);
      logic [3:0] nib;
      unique case (ph)
         2'd0: nib = 4'h5;
         2'd1: nib = 4'h9;
         2'd2: nib = 4'hA;
         2'd3: nib = 4'h6;
         default: nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage

// ===== src/svms_front.sv =====
// ----------------------------------------------------------------------------
// svms_front
// Unpacks a request transaction and classifies it (valve check, chain).
// ----------------------------------------------------------------------------
module svms_front (
   input  logic [svms_pkg::REQ_DATA_W-1:0] req_data,
   input  logic [svms_pkg::REQ_USER_W-1:0] req_user,
   output svms_pkg::item_type              item
);

   logic [svms_pkg::VALVE_W-1:0] valve;

   assign valve = req_data[3:0];

   always_comb begin
      item          = '0;
      item.cmd      = svms_pkg::cmd_type'(req_user);
      item.valve    = valve;
      item.valve_ok = valve < svms_pkg::VALVE_W'(svms_pkg::NUM_VALVES);
      item.chain    = valve >= svms_pkg::VALVE_W'(svms_pkg::VALVES_PER_CHAIN);
      item.dir      = req_data[4];
      item.amount   = req_data[9:5];
      item.target   = req_data[14:10];
   end

endmodule

// ===== src/svms_queue.sv =====
// ----------------------------------------------------------------------------
// svms_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module svms_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  svms_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output svms_pkg::item_type pop_item
);

   svms_pkg::item_type                 slots_ff [svms_pkg::QUEUE_DEPTH];
   logic [svms_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [svms_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [svms_pkg::QUEUE_PTR_W:0]     count_ff, count_in;
   logic                               push, pop;

   assign push_ready = count_ff != (svms_pkg::QUEUE_PTR_W+1)'(svms_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/svms_back.sv =====
// ----------------------------------------------------------------------------
// svms_back
// Executes queued requests: position tracking, move checks, coil word runs,
// configuration registers and the registered result stage.
// ----------------------------------------------------------------------------
module svms_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [svms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [svms_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  svms_pkg::item_type                in_item,
   output logic                              out_valid,
   input  logic                              out_ready,
   output svms_pkg::rsp_type                 out_rsp
);

   localparam int RUN_PROD_W = svms_pkg::SPU_W + svms_pkg::POS_W;

   logic                              check_ff, check_in;
   logic                              store_ff, store_in;
   logic [svms_pkg::SPU_W-1:0]        spu_ff, spu_in;

   logic [svms_pkg::POS_W-1:0]        positions_ff [svms_pkg::NUM_VALVES];
   logic                              busy_ff, busy_in;
   logic [svms_pkg::WORDS_W-1:0]      words_ff, words_in;
   logic [1:0]                        phase_ff, phase_in;
   logic [svms_pkg::VALVE_W-1:0]      act_valve_ff, act_valve_in;
   logic                              act_dir_ff, act_dir_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   svms_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                              fire;
   logic                              pos_we;
   logic [svms_pkg::POS_W-1:0]        pos_wdata;
   logic [svms_pkg::POS_W-1:0]        pos;
   logic                              mv_dir;
   logic [svms_pkg::AMOUNT_W-1:0]     mv_amt;
   logic [svms_pkg::POS_W-1:0]        room;
   logic [svms_pkg::POS_W-1:0]        run_open, run_close, run;
   logic [svms_pkg::POS_W-1:0]        moved_pos;
   logic                              raw_bad;
   logic [RUN_PROD_W-1:0]             run_prod;
   logic                              act_chain;
   logic [svms_pkg::VALVE_W-1:0]      slot_wide;
   logic [svms_pkg::SLOT_W-1:0]       slot;
   logic [1:0]                        drive_ph;
   logic [svms_pkg::WORD_W-1:0]       drive_word;

   assign in_ready  = !rsp_valid_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

   always_comb begin
      check_in = check_ff;
      store_in = store_ff;
      spu_in   = spu_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            svms_pkg::CSR_CHECK_MODE:      check_in = csr_wdata[0];
            svms_pkg::CSR_STORE_POSITIONS: store_in = csr_wdata[0];
            svms_pkg::CSR_STEPS_PER_UNIT:  spu_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // move arithmetic
   always_comb begin
      pos = in_item.valve_ok ? positions_ff[in_item.valve] : '0;
      if (in_item.cmd == svms_pkg::CMD_TARGET) begin
         if (pos > in_item.target) begin
            mv_dir = 1'b0;
            mv_amt = pos - in_item.target;
         end else begin
            mv_dir = 1'b1;
            mv_amt = in_item.target - pos;
         end
      end else begin
         mv_dir = in_item.dir;
         mv_amt = in_item.amount;
      end
      room      = svms_pkg::POS_W'(svms_pkg::MAX_POSITION) - pos;
      run_open  = (mv_amt < room) ? mv_amt : room;
      run_close = (mv_amt < pos) ? mv_amt : pos;
      run       = check_ff ? (mv_dir ? run_open : run_close) : mv_amt;
      moved_pos = mv_dir ? pos + run : pos - run;
      raw_bad   = ({1'b0, pos} + {1'b0, mv_amt} >
                   (svms_pkg::POS_W+1)'(svms_pkg::MAX_POSITION)) || (mv_amt > pos);
      run_prod  = RUN_PROD_W'(spu_ff) * RUN_PROD_W'(run);
   end

   // coil word of the active run
   always_comb begin
      act_chain  = act_valve_ff >= svms_pkg::VALVE_W'(svms_pkg::VALVES_PER_CHAIN);
      slot_wide  = act_chain ?
                   act_valve_ff - svms_pkg::VALVE_W'(svms_pkg::VALVES_PER_CHAIN) :
                   act_valve_ff;
      slot       = slot_wide[svms_pkg::SLOT_W-1:0];
      drive_ph   = act_dir_ff ? phase_ff : ~phase_ff;
      drive_word = svms_pkg::WORD_W'(svms_pkg::phase_nibble(drive_ph)) << {slot, 2'b00};
   end

   always_comb begin
      busy_in      = busy_ff;
      words_in     = words_ff;
      phase_in     = phase_ff;
      act_valve_in = act_valve_ff;
      act_dir_in   = act_dir_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_in       = rsp_ff;
      pos_we       = 1'b0;
      pos_wdata    = in_item.target;

      if (fire) begin
         if (in_item.cmd == svms_pkg::CMD_TICK) begin
            if (busy_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.kind   = svms_pkg::KIND_DRIVE;
               rsp_in.chain  = act_chain;
               rsp_in.status = svms_pkg::ST_ACCEPTED;
               if (words_ff != '0) begin
                  rsp_in.word = drive_word;
                  phase_in    = phase_ff + 1'b1;
                  words_in    = words_ff - 1'b1;
               end else begin
                  rsp_in.last = 1'b1;
                  busy_in     = 1'b0;
               end
            end
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_in        = '0;
            rsp_in.kind   = svms_pkg::KIND_STATUS;
            rsp_in.chain  = in_item.chain;
            rsp_in.pos    = pos;
            rsp_in.status = svms_pkg::ST_ACCEPTED;
            priority if (busy_ff) begin
               rsp_in.status = svms_pkg::ST_BUSY;
            end else if (!in_item.valve_ok) begin
               rsp_in.status = svms_pkg::ST_RANGE;
            end else if (in_item.cmd == svms_pkg::CMD_LOAD) begin
               if (in_item.target > svms_pkg::POS_W'(svms_pkg::MAX_POSITION)) begin
                  rsp_in.status = svms_pkg::ST_RANGE;
               end else begin
                  pos_we     = 1'b1;
                  pos_wdata  = in_item.target;
                  rsp_in.pos = in_item.target;
               end
            end else if (in_item.cmd == svms_pkg::CMD_MOVE &&
                         in_item.amount > svms_pkg::AMOUNT_W'(svms_pkg::MAX_POSITION)) begin
               rsp_in.status = svms_pkg::ST_AMOUNT;
            end else if (!check_ff && raw_bad) begin
               rsp_in.status = svms_pkg::ST_RANGE;
            end else begin
               busy_in      = 1'b1;
               words_in     = svms_pkg::WORDS_W'({run_prod, 2'b00});
               phase_in     = '0;
               act_valve_in = in_item.valve;
               act_dir_in   = mv_dir;
               if (check_ff && store_ff) begin
                  pos_we     = 1'b1;
                  pos_wdata  = moved_pos;
                  rsp_in.pos = moved_pos;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff     <= 1'b1;
         store_ff     <= 1'b1;
         spu_ff       <= svms_pkg::SPU_RESET;
         busy_ff      <= 1'b0;
         words_ff     <= '0;
         phase_ff     <= '0;
         act_valve_ff <= '0;
         act_dir_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < svms_pkg::NUM_VALVES; i++) begin
            positions_ff[i] <= '0;
         end
      end else begin
         check_ff     <= check_in;
         store_ff     <= store_in;
         spu_ff       <= spu_in;
         busy_ff      <= busy_in;
         words_ff     <= words_in;
         phase_ff     <= phase_in;
         act_valve_ff <= act_valve_in;
         act_dir_ff   <= act_dir_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pos_we) begin
            positions_ff[in_item.valve] <= pos_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ===== src/stepper_valve_move_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// stepper_valve_move_sequencer_core
// Tracks 12 stepper valve positions, checks move requests and emits coil
// drive word runs on two shift chains.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tdata, tuser (command)
//   rsp      out        rsp_tvalid/tready    tdata, tuser, tlast
//   csr      in         csr_write_en         csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_tready stays high; the back unit
// retires one queued request per cycle whenever its output register is free.
// A request passes the queue, then the result register, on its way to a result.
// Reset is synchronous: registers return to defaults, positions to zero.
// A stalled result holds the back; the 4-entry queue absorbs requests until
// req_tready drops.
// ----------------------------------------------------------------------------
module stepper_valve_move_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [3:0] valve_index, [4] move_direction, [9:5] move_amount,
   // [14:10] target_position, [15] zero
   input  logic [svms_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] command
   input  logic [svms_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [23:0] drive_word, [25:24] status, [30:26] new_position, [31] zero
   output logic [svms_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] result_kind, [1] chain_select
   output logic [svms_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_write_en,
   input  logic [svms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [svms_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   svms_pkg::item_type front_item;
   svms_pkg::item_type queue_item;
   svms_pkg::rsp_type  rsp;
   logic               queue_valid;
   logic               back_ready;

   svms_front u_front (
      .req_data (req_tdata),
      .req_user (req_tuser),
      .item     (front_item)
   );

   svms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_item   (queue_item)
   );

   svms_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_valid     (queue_valid),
      .in_ready     (back_ready),
      .in_item      (queue_item),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_rsp      (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.pos, rsp.status, rsp.word};
   assign rsp_tuser = {rsp.chain, rsp.kind};
   assign rsp_tlast = rsp.last;

endmodule
